### hw/rtl/gauss_jordan_matrix_inverse_top_defines.svh
// Assertion macros used by the matrix inverter top level.
`ifndef GAUSS_JORDAN_MATRIX_INVERSE_TOP_DEFINES_SVH
`define GAUSS_JORDAN_MATRIX_INVERSE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GJINV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GJINV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GJINV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GJINV_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/gjinv_pkg.sv
// Shared types and constants of the matrix inverter.
`timescale 1ns / 1ps
package gjinv_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 4;

    typedef enum logic [2:0] {
        WS_IN   = 3'd0,
        WS_ONE  = 3'd1,
        WS_ZERO = 3'd2,
        WS_RD   = 3'd3,
        WS_HOLD = 3'd4,
        WS_DIV  = 3'd5,
        WS_ELIM = 3'd6
    } t_wr_sel;

    typedef struct packed {
        logic    rd_en;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    latch_a;
        logic    piv_load;
        logic    pivot_load;
        logic    div_start;
        logic    fac_load;
        logic    mul_load;
        logic    out_load;
        logic    out_last;
        logic    out_sing;
    } t_dp_cmd;

    typedef struct packed {
        logic mag_gt;
        logic rd_zero;
        logic div_done;
    } t_dp_stat;

endpackage

### hw/rtl/gauss_jordan_matrix_inverse_top.sv
// Loading accepts one element per cycle while o_in_stall is low; the inverse starts after
// a Gauss-Jordan pass, which normalizes each pivot row with the divider (2n^2 entries in all),
// eliminates with a multiply-subtract per updated entry, and swaps rows where needed.
// Each result is held while i_out_stall is high; one matrix is in work at a time.
// Synchronous active-low reset returns to loading with size 8 (or MAX_N if smaller).
// The matrix store is not cleared by reset; every entry is written before it is read.
`timescale 1ns / 1ps
`include "gauss_jordan_matrix_inverse_top_defines.svh"
module gauss_jordan_matrix_inverse_top #(
    parameter int MAX_N     = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [gjinv_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [gjinv_pkg::DATA_W-1:0] i_element_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [gjinv_pkg::DATA_W-1:0] o_inverse_value,
    output logic                         o_last_of_matrix,
    output logic                         o_singular
);
    import gjinv_pkg::*;

    localparam int AW = $clog2(2 * MAX_N * MAX_N);

    t_dp_cmd         w_cmd;
    t_dp_stat        w_stat;
    logic [AW-1:0]   w_addr;

    gjinv_ctrl #(
        .MAX_N(MAX_N)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_cfg_ready(o_cfg_ready),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_cmd      (w_cmd),
        .o_addr     (w_addr),
        .i_stat     (w_stat)
    );

    gjinv_dp #(
        .MAX_N    (MAX_N),
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_addr          (w_addr),
        .i_element_value (i_element_value),
        .o_stat          (w_stat),
        .o_inverse_value (o_inverse_value),
        .o_last_of_matrix(o_last_of_matrix),
        .o_singular      (o_singular)
    );

    `GJINV_ASSERT_IMP(a_no_load_during_output, i_clk, i_rst_n, (i_in_valid && !o_in_stall), !o_out_valid)
    `GJINV_ASSERT_NXT(a_load_after_last, i_clk, i_rst_n, (o_out_valid && !i_out_stall && o_last_of_matrix), !o_in_stall || i_cfg_valid)
    `GJINV_ASSERT_IMP(a_singular_zero, i_clk, i_rst_n, (o_out_valid && o_singular), (o_inverse_value == '0))
    `GJINV_ASSERT_NXT(a_cfg_no_output, i_clk, i_rst_n, (i_cfg_valid && o_cfg_ready), !o_out_valid)
endmodule

### hw/rtl/gjinv_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module gjinv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

### hw/rtl/gjinv_div.sv
// Radix-2 restoring divider: (x * 2^FRAC_BITS) / d, truncated and saturated.
`timescale 1ns / 1ps
module gjinv_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gjinv_pkg::DATA_W-1:0] i_dividend,
    input  logic [gjinv_pkg::DATA_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [gjinv_pkg::DATA_W-1:0] o_quotient
);
    import gjinv_pkg::*;

    localparam int DW   = DATA_W + FRAC_BITS;
    localparam int CNTW = $clog2(DW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNTW-1:0]   r_cnt;
    logic [DW-1:0]     r_num;
    logic [DW-1:0]     r_quo;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_den;
    logic              r_neg;

    logic [DATA_W-1:0] w_num_mag;
    logic [DATA_W-1:0] w_den_mag;
    logic [DATA_W:0]   w_trial;
    logic              w_fits;
    logic              w_pos_ovf;
    logic              w_neg_ovf;

    assign w_num_mag = i_dividend[DATA_W-1] ? (DATA_W'(0) - i_dividend) : i_dividend;
    assign w_den_mag = i_divisor[DATA_W-1] ? (DATA_W'(0) - i_divisor) : i_divisor;
    assign w_trial   = {r_rem, r_num[DW-1]};
    assign w_fits    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= DW'(w_num_mag) << FRAC_BITS;
            r_den <= w_den_mag;
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            r_num <= {r_num[DW-2:0], 1'b0};
            if (w_fits) begin
                r_rem <= DATA_W'(w_trial - {1'b0, r_den});
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DATA_W-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
    end

    assign w_pos_ovf = |r_quo[DW-1:DATA_W-1];
    assign w_neg_ovf = (|r_quo[DW-1:DATA_W]) || (r_quo[DATA_W-1] && (|r_quo[DATA_W-2:0]));

    always_comb begin
        if (r_neg) begin
            o_quotient = w_neg_ovf ? {1'b1, {(DATA_W-1){1'b0}}}
                                   : (DATA_W'(0) - r_quo[DATA_W-1:0]);
        end else begin
            o_quotient = w_pos_ovf ? {1'b0, {(DATA_W-1){1'b1}}}
                                   : {1'b0, r_quo[DATA_W-2:0]};
        end
    end

    assign o_done = r_done;
endmodule

### hw/rtl/gjinv_dp.sv
// Datapath: augmented matrix store, pivot compare, multiply-subtract, divider, output register.
`timescale 1ns / 1ps
module gjinv_dp #(
    parameter int MAX_N     = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gjinv_pkg::t_dp_cmd                  i_cmd,
    input  logic [$clog2(2*MAX_N*MAX_N)-1:0]    i_addr,
    input  logic [gjinv_pkg::DATA_W-1:0]        i_element_value,
    output gjinv_pkg::t_dp_stat                 o_stat,
    output logic [gjinv_pkg::DATA_W-1:0]        o_inverse_value,
    output logic                                o_last_of_matrix,
    output logic                                o_singular
);
    import gjinv_pkg::*;

    localparam int DEPTH = 2 * MAX_N * MAX_N;
    localparam int PW    = 2 * DATA_W;

    logic [DATA_W-1:0]        w_rd;
    logic [DATA_W-1:0]        w_wr_data;
    logic [DATA_W-1:0]        w_quot;
    logic [DATA_W:0]          w_rd_ext;
    logic [DATA_W:0]          w_mag;
    logic signed [PW-1:0]     w_q;
    logic signed [PW-1:0]     w_diff;
    logic [DATA_W-1:0]        w_elim;
    logic [PW-1:0]            w_frac_mask;

    logic [DATA_W-1:0]        r_a;
    logic [DATA_W:0]          r_bestmag;
    logic [DATA_W-1:0]        r_pivot;
    logic [DATA_W-1:0]        r_fac;
    logic signed [PW-1:0]     r_prod;
    logic [DATA_W-1:0]        r_x;
    logic [DATA_W-1:0]        r_out_val;
    logic                     r_out_last;
    logic                     r_out_sing;

    gjinv_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.wr_en),
        .i_wr_addr(i_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (i_cmd.rd_en),
        .i_rd_addr(i_addr),
        .o_rd_data(w_rd)
    );

    gjinv_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_dividend(w_rd),
        .i_divisor (r_pivot),
        .o_done    (o_stat.div_done),
        .o_quotient(w_quot)
    );

    assign w_rd_ext = {w_rd[DATA_W-1], w_rd};
    assign w_mag    = w_rd[DATA_W-1] ? ((DATA_W+1)'(0) - w_rd_ext) : w_rd_ext;

    assign o_stat.mag_gt  = (w_mag > r_bestmag);
    assign o_stat.rd_zero = (w_rd == '0);

    // Shift toward minus infinity, then step up by one to truncate toward zero.
    assign w_frac_mask = (PW'(1) << FRAC_BITS) - PW'(1);
    assign w_q = (r_prod >>> FRAC_BITS)
               + PW'((r_prod[PW-1] && (|(r_prod & w_frac_mask))) ? 1 : 0);
    assign w_diff = PW'(signed'(r_x)) - w_q;

    always_comb begin
        if (w_diff > PW'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
            w_elim = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (w_diff < PW'(signed'({1'b1, {(DATA_W-1){1'b0}}}))) begin
            w_elim = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_elim = w_diff[DATA_W-1:0];
        end
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WS_IN:   w_wr_data = i_element_value;
            WS_ONE:  w_wr_data = DATA_W'(1) << FRAC_BITS;
            WS_ZERO: w_wr_data = '0;
            WS_RD:   w_wr_data = w_rd;
            WS_HOLD: w_wr_data = r_a;
            WS_DIV:  w_wr_data = w_quot;
            WS_ELIM: w_wr_data = w_elim;
            default: w_wr_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_a) begin
            r_a <= w_rd;
        end
        if (i_cmd.piv_load) begin
            r_bestmag <= w_mag;
        end
        if (i_cmd.pivot_load) begin
            r_pivot <= w_rd;
        end
        if (i_cmd.fac_load) begin
            r_fac <= w_rd;
        end
        if (i_cmd.mul_load) begin
            r_prod <= PW'(signed'(r_fac)) * PW'(signed'(r_a));
            r_x    <= w_rd;
        end
        if (i_cmd.out_load) begin
            r_out_val  <= i_cmd.out_sing ? '0 : w_rd;
            r_out_last <= i_cmd.out_last;
            r_out_sing <= i_cmd.out_sing;
        end
    end

    assign o_inverse_value  = r_out_val;
    assign o_last_of_matrix = r_out_last;
    assign o_singular       = r_out_sing;
endmodule

### hw/rtl/gjinv_ctrl.sv
// Controller: sequences loading, identity fill, pivot search, swap, normalize, eliminate and output.
`timescale 1ns / 1ps
module gjinv_ctrl #(
    parameter int MAX_N = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [gjinv_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                              o_cfg_ready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output gjinv_pkg::t_dp_cmd                o_cmd,
    output logic [$clog2(2*MAX_N*MAX_N)-1:0]  o_addr,
    input  gjinv_pkg::t_dp_stat               i_stat
);
    import gjinv_pkg::*;

    localparam int AW         = $clog2(2 * MAX_N * MAX_N);
    localparam int RW         = $clog2(MAX_N);
    localparam int CW         = $clog2(2 * MAX_N);
    localparam int NW         = $clog2(MAX_N + 1);
    localparam int ROW_STRIDE = 2 * MAX_N;
    localparam int RESET_N    = (8 > MAX_N) ? MAX_N : 8;

    typedef enum logic [21:0] {
        S_LOAD     = 22'(1) << 0,
        S_IDENT    = 22'(1) << 1,
        S_PV_ADDR  = 22'(1) << 2,
        S_PV_CMP   = 22'(1) << 3,
        S_SW_RA    = 22'(1) << 4,
        S_SW_RB    = 22'(1) << 5,
        S_SW_WA    = 22'(1) << 6,
        S_SW_WB    = 22'(1) << 7,
        S_PIV_RD   = 22'(1) << 8,
        S_PIV_CHK  = 22'(1) << 9,
        S_NM_RD    = 22'(1) << 10,
        S_NM_START = 22'(1) << 11,
        S_NM_WAIT  = 22'(1) << 12,
        S_EL_FRD   = 22'(1) << 13,
        S_EL_FLD   = 22'(1) << 14,
        S_EL_RA    = 22'(1) << 15,
        S_EL_RB    = 22'(1) << 16,
        S_EL_MUL   = 22'(1) << 17,
        S_EL_WR    = 22'(1) << 18,
        S_OUT_RD   = 22'(1) << 19,
        S_OUT_LD   = 22'(1) << 20,
        S_OUT_HOLD = 22'(1) << 21
    } t_state;

    t_state          r_state, n_state;
    logic [NW-1:0]   r_n, n_n;
    logic [RW-1:0]   r_i, n_i;
    logic [RW-1:0]   r_j, n_j;
    logic [RW-1:0]   r_best, n_best;
    logic [CW-1:0]   r_k, n_k;
    logic            r_sing, n_sing;
    logic            r_out_valid, n_out_valid;

    logic [RW-1:0]   w_last_row;
    logic [CW-1:0]   w_last_col;
    logic [RW-1:0]   w_best_nx;
    logic [CFG_W-1:0] w_cfg_n;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
        cell_addr = AW'(row) * AW'(ROW_STRIDE) + AW'(col);
    endfunction

    assign w_last_row = RW'(r_n - NW'(1));
    assign w_last_col = CW'({r_n, 1'b0} - (NW+1)'(1));

    // A size of zero counts as one, and anything above the maximum as the maximum.
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_n = CFG_W'(1);
        end else if ({1'b0, i_cfg_data} > (CFG_W+1)'(MAX_N)) begin
            w_cfg_n = CFG_W'(MAX_N);
        end else begin
            w_cfg_n = i_cfg_data;
        end
    end

    // Strictly larger magnitude wins, so ties keep the row nearest the diagonal.
    assign w_best_nx = ((r_j == r_i) || i_stat.mag_gt) ? r_j : r_best;

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_best      = r_best;
        n_k         = r_k;
        n_sing      = r_sing;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.wr_sel = WS_ZERO;
        o_addr      = '0;

        case (r_state)
            S_LOAD: begin
                if (i_cfg_valid) begin
                    n_n = NW'(w_cfg_n);
                    n_i = '0;
                    n_j = '0;
                end else if (i_in_valid) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WS_IN;
                    o_addr       = cell_addr(r_i, CW'(r_j));
                    if (r_j == w_last_row) begin
                        n_j = '0;
                        if (r_i == w_last_row) begin
                            n_i     = '0;
                            n_state = S_IDENT;
                        end else begin
                            n_i = r_i + RW'(1);
                        end
                    end else begin
                        n_j = r_j + RW'(1);
                    end
                end
            end
            S_IDENT: begin
                n_sing       = 1'b0;
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = (r_i == r_j) ? WS_ONE : WS_ZERO;
                o_addr       = cell_addr(r_i, CW'(r_n) + CW'(r_j));
                if (r_j == w_last_row) begin
                    n_j = '0;
                    if (r_i == w_last_row) begin
                        n_i     = '0;
                        n_state = S_PV_ADDR;
                    end else begin
                        n_i = r_i + RW'(1);
                    end
                end else begin
                    n_j = r_j + RW'(1);
                end
            end
            S_PV_ADDR: begin
                o_cmd.rd_en = 1'b1;
                o_addr      = cell_addr(r_j, CW'(r_i));
                n_state     = S_PV_CMP;
            end
            S_PV_CMP: begin
                o_cmd.piv_load = (r_j == r_i) || i_stat.mag_gt;
                n_best         = w_best_nx;
                if (r_j == w_last_row) begin
                    n_k     = '0;
                    n_state = (w_best_nx != r_i) ? S_SW_RA : S_PIV_RD;
                end else begin
                    n_j     = r_j + RW'(1);
                    n_state = S_PV_ADDR;
                end
            end
            S_SW_RA: begin
                o_cmd.rd_en = 1'b1;
                o_addr      = cell_addr(r_i, r_k);
                n_state     = S_SW_RB;
            end
            S_SW_RB: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.latch_a = 1'b1;
                o_addr        = cell_addr(r_best, r_k);
                n_state       = S_SW_WA;
            end
            S_SW_WA: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_RD;
                o_addr       = cell_addr(r_i, r_k);
                n_state      = S_SW_WB;
            end
            S_SW_WB: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WS_HOLD;
                o_addr       = cell_addr(r_best, r_k);
                if (r_k == w_last_col) begin
                    n_state = S_PIV_RD;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = S_SW_RA;
                end
            end
            S_PIV_RD: begin
                o_cmd.rd_en = 1'b1;
                o_addr      = cell_addr(r_i, CW'(r_i));
                n_state     = S_PIV_CHK;
            end
            S_PIV_CHK: begin
                o_cmd.pivot_load = 1'b1;
                if (i_stat.rd_zero) begin
                    n_sing  = 1'b1;
                    n_i     = '0;
                    n_j     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_k     = '0;
                    n_state = S_NM_RD;
                end
            end
            S_NM_RD: begin
                o_cmd.rd_en = 1'b1;
                o_addr      = cell_addr(r_i, r_k);
                n_state     = S_NM_START;
            end
            S_NM_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_NM_WAIT;
            end
            S_NM_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WS_DIV;
                    o_addr       = cell_addr(r_i, r_k);
                    if (r_k == w_last_col) begin
                        n_j     = '0;
                        n_state = S_EL_FRD;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = S_NM_RD;
                    end
                end
            end
            S_EL_FRD, S_EL_WR: begin
                if (r_state == S_EL_WR) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WS_ELIM;
                    o_addr       = cell_addr(r_j, r_k);
                end else if (r_j != r_i) begin
                    o_cmd.rd_en = 1'b1;
                    o_addr      = cell_addr(r_j, CW'(r_i));
                end
                if ((r_state == S_EL_WR) && (r_k != w_last_col)) begin
                    n_k     = r_k + CW'(1);
                    n_state = S_EL_RA;
                end else if ((r_state == S_EL_FRD) && (r_j != r_i)) begin
                    n_state = S_EL_FLD;
                end else if (r_j == w_last_row) begin
                    // Column finished: move on to the next pivot column, or to output after the last one.
                    if (r_i == w_last_row) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_state = S_OUT_RD;
                    end else begin
                        n_i     = r_i + RW'(1);
                        n_j     = r_i + RW'(1);
                        n_state = S_PV_ADDR;
                    end
                end else begin
                    n_j     = r_j + RW'(1);
                    n_state = S_EL_FRD;
                end
            end
            S_EL_FLD: begin
                o_cmd.fac_load = 1'b1;
                n_k            = CW'(r_i);
                n_state        = S_EL_RA;
            end
            S_EL_RA: begin
                o_cmd.rd_en = 1'b1;
                o_addr      = cell_addr(r_i, r_k);
                n_state     = S_EL_RB;
            end
            S_EL_RB: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.latch_a = 1'b1;
                o_addr        = cell_addr(r_j, r_k);
                n_state       = S_EL_MUL;
            end
            S_EL_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state        = S_EL_WR;
            end
            S_OUT_RD: begin
                o_cmd.rd_en = 1'b1;
                o_addr      = cell_addr(r_i, CW'(r_n) + CW'(r_j));
                n_state     = S_OUT_LD;
            end
            S_OUT_LD: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_last = (r_i == w_last_row) && (r_j == w_last_row);
                o_cmd.out_sing = r_sing;
                n_out_valid    = 1'b1;
                n_state        = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_j == w_last_row) begin
                        n_j = '0;
                        if (r_i == w_last_row) begin
                            n_i     = '0;
                            n_state = S_LOAD;
                        end else begin
                            n_i     = r_i + RW'(1);
                            n_state = S_OUT_RD;
                        end
                    end else begin
                        n_j     = r_j + RW'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_n         <= NW'(RESET_N);
            r_i         <= '0;
            r_j         <= '0;
            r_best      <= '0;
            r_k         <= '0;
            r_sing      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_i         <= n_i;
            r_j         <= n_j;
            r_best      <= n_best;
            r_k         <= n_k;
            r_sing      <= n_sing;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cfg_ready = (r_state == S_LOAD);
    assign o_in_stall  = (r_state != S_LOAD) || i_cfg_valid;
    assign o_out_valid = r_out_valid;
endmodule
